// ----- src/spq_pkg.sv -----
// Package for the sorted priority queue: sizes, request and status codes,
// and the compare result type. No dependencies.
package spq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned TAG_BITS = 32;
  localparam int unsigned PRIO_W   = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  typedef logic [TAG_BITS-1:0]      tag_t;
  typedef logic signed [PRIO_W-1:0] prio_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef enum logic [2:0] {
    REQ_ENQ  = 3'd0,
    REQ_DEQ  = 3'd1,
    REQ_CHG  = 3'd2,
    REQ_PEEK = 3'd3,
    REQ_CLR  = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_RAISED   = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  // result of comparing one stored entry against the key
  typedef struct packed {
    logic served_first; // stored entry is served before the key
    logic tag_eq;       // tags match
    logic prio_lt;      // stored priority below key priority
  } cmp_t;

endpackage

// ----- src/spq_compare.sv -----
// Shared comparator of the sorted priority queue: orders one stored entry
// against the request key. Depends on spq_pkg.
module spq_compare import spq_pkg::*; (
  input  tag_t  ent_tag_i,
  input  prio_t ent_prio_i,
  input  tag_t  key_tag_i,
  input  prio_t key_prio_i,
  output cmp_t  cmp_o
);

  logic prio_eq;

  assign prio_eq            = (ent_prio_i == key_prio_i);
  assign cmp_o.prio_lt      = (ent_prio_i < key_prio_i);
  assign cmp_o.tag_eq       = (ent_tag_i == key_tag_i);
  // priority first, ties broken by unsigned tag
  assign cmp_o.served_first = prio_eq ? (ent_tag_i < key_tag_i) : cmp_o.prio_lt;

endmodule

// ----- src/sorted_priority_queue_unit.sv -----
// Sorted priority queue top level: entry store, walk sequencer, result register.
// Depends on spq_pkg and spq_compare.
// Dequeue, peek, clear and full enqueue finish in DISPATCH; enqueue otherwise walks
// SCAN past the k entries served before the new one, then inserts;
// change priority walks SEARCH, then reinserts through SCAN.
// Next request taken at the strobe's closing edge; receiver cannot stall. Reset empties.
module sorted_priority_queue_unit import spq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type_i,
  input  logic [31:0] item_tag_i,
  input  logic signed [15:0] item_priority_i,
  output logic        result_valid_o,
  output logic [31:0] head_tag_o,
  output logic signed [15:0] head_priority_o,
  output logic [2:0]  status_o,
  output logic [4:0]  entry_count_o,
  output logic        is_empty_o
);

  // Sequencer states:
  //   IDLE     - waits for a request transaction
  //   DISPATCH - decodes the request; single-step requests finish here
  //   SEARCH   - walks the list for the first matching tag (change priority)
  //   SCAN     - walks the list for the insert position, then shifts in
  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_DISPATCH = 2'd1;
  localparam logic [1:0] S_SEARCH   = 2'd2;
  localparam logic [1:0] S_SCAN     = 2'd3;

  logic [1:0] state_q, state_d;
  cnt_t       count_q, count_d;
  cnt_t       idx_q, idx_d;
  logic [2:0] req_q, req_d;
  tag_t       key_tag_q, key_tag_d;
  prio_t      key_prio_q, key_prio_d;

  // entry store, kept sorted; entries at or above count_q are don't-care
  tag_t  tags_q  [CAPACITY];
  tag_t  tags_d  [CAPACITY];
  prio_t prios_q [CAPACITY];
  prio_t prios_d [CAPACITY];

  logic  res_valid_q, res_valid_d;
  tag_t  res_tag_q, res_tag_d;
  prio_t res_prio_q, res_prio_d;
  logic [2:0] res_status_q, res_status_d;
  cnt_t  res_count_q, res_count_d;

  logic  ins_en, rem_en;
  cmp_t  cmp;
  tag_t  ent_tag;
  prio_t ent_prio;

  // the one comparator, pointed at the walk index
  assign ent_tag  = tags_q[idx_q[IDX_W-1:0]];
  assign ent_prio = prios_q[idx_q[IDX_W-1:0]];

  spq_compare u_cmp (
    .ent_tag_i  (ent_tag),
    .ent_prio_i (ent_prio),
    .key_tag_i  (key_tag_q),
    .key_prio_i (key_prio_q),
    .cmp_o      (cmp)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    req_d        = req_q;
    key_tag_d    = key_tag_q;
    key_prio_d   = key_prio_q;
    res_valid_d  = 1'b0;
    res_tag_d    = res_tag_q;
    res_prio_d   = res_prio_q;
    res_status_d = res_status_q;
    ins_en       = 1'b0;
    rem_en       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d      = req_type_i;
          key_tag_d  = TAG_BITS'(item_tag_i);
          key_prio_d = item_priority_i;
          idx_d      = '0;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_tag_d    = '0;
        res_prio_d   = '0;
        res_status_d = ST_OK;
        case (req_q) inside
          REQ_ENQ: begin
            if (count_q == cnt_t'(CAPACITY)) begin
              res_status_d = ST_FULL;
              res_valid_d  = 1'b1;
            end else begin
              state_d = S_SCAN;
            end
          end
          REQ_DEQ, REQ_PEEK: begin
            if (count_q == '0) begin
              res_status_d = ST_EMPTY;
            end else begin
              res_tag_d  = tags_q[0];
              res_prio_d = prios_q[0];
              if (req_q == REQ_DEQ) begin
                rem_en  = 1'b1;  // idx_q is zero here
                count_d = count_q - cnt_t'(1);
              end
            end
            res_valid_d = 1'b1;
          end
          REQ_CHG: state_d = S_SEARCH;
          REQ_CLR: begin
            count_d     = '0;
            res_valid_d = 1'b1;
          end
          default: res_valid_d = 1'b1;  // unused codes: no effect
        endcase
      end
      S_SEARCH: begin
        if (idx_q == count_q) begin
          res_status_d = ST_NOTFOUND;
          res_valid_d  = 1'b1;
        end else if (cmp.tag_eq) begin
          if (cmp.prio_lt) begin
            res_status_d = ST_RAISED;
            res_valid_d  = 1'b1;
          end else begin
            // pull the entry out, then reinsert from the head
            rem_en  = 1'b1;
            count_d = count_q - cnt_t'(1);
            idx_d   = '0;
            state_d = S_SCAN;
          end
        end else begin
          idx_d = idx_q + cnt_t'(1);
        end
      end
      S_SCAN: begin
        if (idx_q == count_q || !cmp.served_first) begin
          ins_en      = 1'b1;
          count_d     = count_q + cnt_t'(1);
          res_valid_d = 1'b1;
        end else begin
          idx_d = idx_q + cnt_t'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (res_valid_d) begin
      state_d = S_IDLE;
    end
    res_count_d = res_valid_d ? count_d : res_count_q;
  end

  // store update: shift up from the insert point, or down over the removed one
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      tags_d[i]  = tags_q[i];
      prios_d[i] = prios_q[i];
    end
    for (int i = 1; i < CAPACITY; i++) begin
      if (ins_en && cnt_t'(i) > idx_q) begin
        tags_d[i]  = tags_q[i-1];
        prios_d[i] = prios_q[i-1];
      end
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (ins_en && cnt_t'(i) == idx_q) begin
        tags_d[i]  = key_tag_q;
        prios_d[i] = key_prio_q;
      end
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      if (rem_en && cnt_t'(i) >= idx_q) begin
        tags_d[i]  = tags_q[i+1];
        prios_d[i] = prios_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload: no reset
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    req_q        <= req_d;
    key_tag_q    <= key_tag_d;
    key_prio_q   <= key_prio_d;
    res_tag_q    <= res_tag_d;
    res_prio_q   <= res_prio_d;
    res_status_q <= res_status_d;
    res_count_q  <= res_count_d;
    for (int i = 0; i < CAPACITY; i++) begin
      tags_q[i]  <= tags_d[i];
      prios_q[i] <= prios_d[i];
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign result_valid_o  = res_valid_q;
  assign head_tag_o      = 32'(res_tag_q);
  assign head_priority_o = res_prio_q;
  assign status_o        = res_status_q;
  assign entry_count_o   = 5'(res_count_q);
  assign is_empty_o      = (res_count_q == '0);

endmodule
